// ===== hw/rtl/bpa_pkg.sv =====
// Shared constants, codes and control structures for the buddy page allocator.
package bpa_pkg;

    localparam int MAX_PAGES  = 4096;
    localparam int NUM_ORDERS = 11;
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int LINK_W     = PAGE_W + 1;
    localparam int ORD_W      = 4;
    localparam int BASE_W     = 52;
    localparam int FRAME_W    = BASE_W + 1;
    localparam int PCNT_W     = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BASE_W;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_PAGES);
    localparam logic [ORD_W-1:0]  TOP_ORD  = ORD_W'(NUM_ORDERS - 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'b1;

    // Request modes.
    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // Per-page record: allocated bit and block order.
    typedef struct packed {
        logic             alloc;
        logic [ORD_W-1:0] ord;
    } t_meta;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              meta_re;
        logic [PAGE_W-1:0] meta_raddr;
        logic              meta_we;
        logic [PAGE_W-1:0] meta_waddr;
        t_meta             meta_wdata;
        logic              link_re;
        logic [PAGE_W-1:0] link_raddr;
        logic              nxt_we;
        logic [PAGE_W-1:0] nxt_waddr;
        logic [LINK_W-1:0] nxt_wdata;
        logic              prv_we;
        logic [PAGE_W-1:0] prv_waddr;
        logic [LINK_W-1:0] prv_wdata;
        logic [ORD_W-1:0]  lst_ord;
        logic              head_we;
        logic [LINK_W-1:0] head_wdata;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              lists_clear;
        logic              total_add;
        logic              total_sub;
        logic [ORD_W-1:0]  total_ord;
        logic              pool_latch;
        logic              frame_calc;
        logic [PAGE_W-1:0] frame_page;
        logic [ORD_W-1:0]  buddy_ord;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_meta             meta_rdata;
        logic [LINK_W-1:0] nxt_rdata;
        logic [LINK_W-1:0] prv_rdata;
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] count;
        logic [LINK_W-1:0] total;
        logic [LINK_W-1:0] pool_pages;
        logic [LINK_W-1:0] buddy;
    } t_dp_stat;

endpackage

// ===== hw/rtl/bpa_req_if.sv =====
// Request channel: valid/ready handshake with mode, order and page index.
interface bpa_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [bpa_pkg::ORD_W-1:0]   order;
    logic [bpa_pkg::PAGE_W-1:0]  page_index;

    modport source (output valid, mode, order, page_index, input ready);
    modport sink   (input valid, mode, order, page_index, output ready);
endinterface

// ===== hw/rtl/bpa_rsp_if.sv =====
// Response channel: valid/ready handshake with status, block index and free count.
interface bpa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [bpa_pkg::PAGE_W-1:0]  block_index;
    logic [bpa_pkg::LINK_W-1:0]  free_pages;

    modport source (output valid, status, block_index, free_pages, input ready);
    modport sink   (input valid, status, block_index, free_pages, output ready);
endinterface

// ===== hw/rtl/bpa_datapath.sv =====
// Allocator datapath: page memories, free list heads and counts, totals and buddy math.
module bpa_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  bpa_pkg::t_dp_cmd             i_cmd,
    output bpa_pkg::t_dp_stat            o_stat
);

    // Page records and list links; written before they are read.
    bpa_pkg::t_meta                   r_meta_mem [bpa_pkg::MAX_PAGES];
    logic [bpa_pkg::LINK_W-1:0]       r_nxt_mem  [bpa_pkg::MAX_PAGES];
    logic [bpa_pkg::LINK_W-1:0]       r_prv_mem  [bpa_pkg::MAX_PAGES];
    bpa_pkg::t_meta                   r_meta_rd;
    logic [bpa_pkg::LINK_W-1:0]       r_nxt_rd;
    logic [bpa_pkg::LINK_W-1:0]       r_prv_rd;

    logic [bpa_pkg::LINK_W-1:0]       r_head  [bpa_pkg::NUM_ORDERS];
    logic [bpa_pkg::LINK_W-1:0]       r_count [bpa_pkg::NUM_ORDERS];
    logic [bpa_pkg::LINK_W-1:0]       r_total;

    logic [bpa_pkg::BASE_W-1:0]       r_base_frame;
    logic [bpa_pkg::PCNT_W-1:0]       r_page_count;
    logic [bpa_pkg::BASE_W-1:0]       r_pool_base;
    logic [bpa_pkg::LINK_W-1:0]       r_pool_pages;
    logic [bpa_pkg::FRAME_W-1:0]      r_frame;

    logic [bpa_pkg::FRAME_W-1:0]      buddy_frame;
    logic [bpa_pkg::FRAME_W:0]        buddy_diff;
    logic [bpa_pkg::LINK_W-1:0]       total_amt;
    logic [bpa_pkg::ORD_W-1:0]        sel_ord;

    assign sel_ord   = (i_cmd.lst_ord > bpa_pkg::TOP_ORD) ? bpa_pkg::TOP_ORD : i_cmd.lst_ord;
    assign total_amt = bpa_pkg::LINK_W'(1) << i_cmd.total_ord;

    // Page memories, one write and one registered read per memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.meta_we) begin
            r_meta_mem[i_cmd.meta_waddr] <= i_cmd.meta_wdata;
        end
        if (i_cmd.meta_re) begin
            r_meta_rd <= r_meta_mem[i_cmd.meta_raddr];
        end
        if (i_cmd.nxt_we) begin
            r_nxt_mem[i_cmd.nxt_waddr] <= i_cmd.nxt_wdata;
        end
        if (i_cmd.prv_we) begin
            r_prv_mem[i_cmd.prv_waddr] <= i_cmd.prv_wdata;
        end
        if (i_cmd.link_re) begin
            r_nxt_rd <= r_nxt_mem[i_cmd.link_raddr];
            r_prv_rd <= r_prv_mem[i_cmd.link_raddr];
        end
    end

    // Configuration, pool bounds, list heads, counts and the free total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_frame <= '0;
            r_page_count <= bpa_pkg::PCNT_W'(bpa_pkg::MAX_PAGES);
            r_pool_base  <= '0;
            r_pool_pages <= '0;
            r_total      <= '0;
            for (int k = 0; k < bpa_pkg::NUM_ORDERS; k++) begin
                r_head[k]  <= bpa_pkg::NIL_LINK;
                r_count[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bpa_pkg::CFG_BASE_FRAME: r_base_frame <= i_cfg_data;
                    bpa_pkg::CFG_PAGE_COUNT: r_page_count <= i_cfg_data[bpa_pkg::PCNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.pool_latch) begin
                r_pool_base  <= r_base_frame;
                r_pool_pages <= (r_page_count > bpa_pkg::PCNT_W'(bpa_pkg::MAX_PAGES)) ?
                                bpa_pkg::LINK_W'(bpa_pkg::MAX_PAGES) :
                                bpa_pkg::LINK_W'(r_page_count);
            end
            if (i_cmd.lists_clear) begin
                r_total <= '0;
                for (int k = 0; k < bpa_pkg::NUM_ORDERS; k++) begin
                    r_head[k]  <= bpa_pkg::NIL_LINK;
                    r_count[k] <= '0;
                end
            end else begin
                if (i_cmd.head_we) begin
                    r_head[sel_ord] <= i_cmd.head_wdata;
                end
                if (i_cmd.cnt_inc) begin
                    r_count[sel_ord] <= r_count[sel_ord] + 1'b1;
                end else if (i_cmd.cnt_dec) begin
                    r_count[sel_ord] <= r_count[sel_ord] - 1'b1;
                end
                if (i_cmd.total_add) begin
                    r_total <= r_total + total_amt;
                end else if (i_cmd.total_sub) begin
                    r_total <= r_total - total_amt;
                end
            end
        end
    end

    // Absolute frame of the current page, registered before the buddy step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_calc) begin
            r_frame <= {1'b0, r_pool_base} + bpa_pkg::FRAME_W'(i_cmd.frame_page);
        end
    end

    // Buddy frame back to a pool index; outside the pool it is the null link.
    assign buddy_frame = r_frame ^ (bpa_pkg::FRAME_W'(1) << i_cmd.buddy_ord);
    assign buddy_diff  = {1'b0, buddy_frame} - {2'b00, r_pool_base};

    always_comb begin
        o_stat            = '0;
        o_stat.meta_rdata = r_meta_rd;
        o_stat.nxt_rdata  = r_nxt_rd;
        o_stat.prv_rdata  = r_prv_rd;
        o_stat.head       = r_head[sel_ord];
        o_stat.count      = r_count[sel_ord];
        o_stat.total      = r_total;
        o_stat.pool_pages = r_pool_pages;
        if (buddy_diff[bpa_pkg::FRAME_W] ||
            (buddy_diff[bpa_pkg::FRAME_W-1:0] >= bpa_pkg::FRAME_W'(r_pool_pages))) begin
            o_stat.buddy = bpa_pkg::NIL_LINK;
        end else begin
            o_stat.buddy = buddy_diff[bpa_pkg::LINK_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/bpa_ctrl.sv =====
// Allocator controller: request sequencing, list and merge steps, response register.
module bpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpa_req_if.sink           i_req,
    bpa_rsp_if.source         o_rsp,
    output bpa_pkg::t_dp_cmd  o_cmd,
    input  bpa_pkg::t_dp_stat i_stat
);

    typedef enum logic [4:0] {
        S_IDLE, S_INIT0, S_MARK, S_IFREE, S_FB1, S_MG0, S_MG1, S_MG2, S_MG3, S_MG4,
        S_FBEND, S_ALLOC0, S_ASRCH, S_ASPL, S_ASPL1, S_ASPL2, S_ASPL3, S_AFIN,
        S_FREE0, S_FREE1, S_PUSH1, S_PUSH2, S_DROP0, S_DROP1, S_BD0, S_BD1, S_DONE
    } t_state;

    t_state                       r_state;
    t_state                       r_ret;
    logic                         r_init;
    logic [bpa_pkg::ORD_W-1:0]    r_ord;
    logic [bpa_pkg::ORD_W-1:0]    r_o;
    logic [bpa_pkg::PAGE_W-1:0]   r_idx;
    logic [bpa_pkg::PAGE_W-1:0]   r_p;
    logic [bpa_pkg::PAGE_W-1:0]   r_arg;
    logic [bpa_pkg::LINK_W-1:0]   r_b;
    logic [bpa_pkg::LINK_W-1:0]   r_i;
    logic [1:0]                   r_st;
    logic [bpa_pkg::PAGE_W-1:0]   r_blk;
    logic                         r_out_valid;
    logic [1:0]                   r_out_status;
    logic [bpa_pkg::PAGE_W-1:0]   r_out_block;
    logic [bpa_pkg::LINK_W-1:0]   r_out_free;

    logic [bpa_pkg::ORD_W-1:0]    clip_ord;
    logic [bpa_pkg::PAGE_W-1:0]   b_page;
    logic [bpa_pkg::PAGE_W-1:0]   merged_p;
    logic                         out_free;

    assign clip_ord = (i_stat.meta_rdata.ord > bpa_pkg::TOP_ORD) ?
                      bpa_pkg::TOP_ORD : i_stat.meta_rdata.ord;
    assign b_page   = r_b[bpa_pkg::PAGE_W-1:0];
    assign merged_p = (b_page < r_p) ? b_page : r_p;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.block_index = r_out_block;
    assign o_rsp.free_pages  = r_out_free;

    // Datapath commands for the current step.
    always_comb begin
        o_cmd            = '0;
        o_cmd.lst_ord    = r_o;
        o_cmd.frame_page = r_p;
        o_cmd.buddy_ord  = r_o;
        o_cmd.link_raddr = r_arg;
        unique case (r_state)
            S_INIT0: begin
                o_cmd.pool_latch  = 1'b1;
                o_cmd.lists_clear = 1'b1;
            end
            S_MARK: begin
                if (r_i < i_stat.pool_pages) begin
                    o_cmd.meta_we    = 1'b1;
                    o_cmd.meta_waddr = r_i[bpa_pkg::PAGE_W-1:0];
                    o_cmd.meta_wdata = '{alloc: 1'b1, ord: '0};
                end
            end
            S_IFREE: begin
                o_cmd.meta_re    = 1'b1;
                o_cmd.meta_raddr = r_i[bpa_pkg::PAGE_W-1:0];
            end
            S_FREE0: begin
                o_cmd.meta_re    = 1'b1;
                o_cmd.meta_raddr = r_idx;
            end
            S_FB1: begin
                o_cmd.meta_we    = 1'b1;
                o_cmd.meta_waddr = r_p;
                o_cmd.meta_wdata = '{alloc: 1'b0, ord: clip_ord};
                o_cmd.total_add  = 1'b1;
                o_cmd.total_ord  = clip_ord;
            end
            S_MG1: begin
                o_cmd.meta_re    = 1'b1;
                o_cmd.meta_raddr = b_page;
            end
            S_MG4: begin
                o_cmd.meta_we    = 1'b1;
                o_cmd.meta_waddr = merged_p;
                o_cmd.meta_wdata = '{alloc: 1'b0, ord: r_o + 1'b1};
            end
            S_ASPL1: begin
                o_cmd.meta_we    = 1'b1;
                o_cmd.meta_waddr = r_p;
                o_cmd.meta_wdata = '{alloc: 1'b0, ord: r_o - 1'b1};
            end
            S_ASPL2: begin
                o_cmd.meta_we    = (r_b != bpa_pkg::NIL_LINK);
                o_cmd.meta_waddr = b_page;
                o_cmd.meta_wdata = '{alloc: 1'b0, ord: r_o};
            end
            S_AFIN: begin
                o_cmd.meta_we    = 1'b1;
                o_cmd.meta_waddr = r_p;
                o_cmd.meta_wdata = '{alloc: 1'b1, ord: r_ord};
                o_cmd.total_sub  = 1'b1;
                o_cmd.total_ord  = r_ord;
            end
            S_PUSH1: begin
                o_cmd.nxt_we    = 1'b1;
                o_cmd.nxt_waddr = r_arg;
                o_cmd.nxt_wdata = i_stat.head;
                o_cmd.prv_we    = 1'b1;
                o_cmd.prv_waddr = r_arg;
                o_cmd.prv_wdata = bpa_pkg::NIL_LINK;
            end
            S_PUSH2: begin
                o_cmd.prv_we     = (i_stat.head != bpa_pkg::NIL_LINK);
                o_cmd.prv_waddr  = i_stat.head[bpa_pkg::PAGE_W-1:0];
                o_cmd.prv_wdata  = bpa_pkg::LINK_W'(r_arg);
                o_cmd.head_we    = 1'b1;
                o_cmd.head_wdata = bpa_pkg::LINK_W'(r_arg);
                o_cmd.cnt_inc    = 1'b1;
            end
            S_DROP0: begin
                o_cmd.link_re = 1'b1;
            end
            S_DROP1: begin
                // Unlink: predecessor (or head) skips to the successor.
                o_cmd.nxt_we     = (i_stat.prv_rdata != bpa_pkg::NIL_LINK);
                o_cmd.nxt_waddr  = i_stat.prv_rdata[bpa_pkg::PAGE_W-1:0];
                o_cmd.nxt_wdata  = i_stat.nxt_rdata;
                o_cmd.head_we    = (i_stat.prv_rdata == bpa_pkg::NIL_LINK);
                o_cmd.head_wdata = i_stat.nxt_rdata;
                o_cmd.prv_we     = (i_stat.nxt_rdata != bpa_pkg::NIL_LINK);
                o_cmd.prv_waddr  = i_stat.nxt_rdata[bpa_pkg::PAGE_W-1:0];
                o_cmd.prv_wdata  = i_stat.prv_rdata;
                o_cmd.cnt_dec    = 1'b1;
            end
            S_BD0: begin
                o_cmd.frame_calc = 1'b1;
            end
            default: ;
        endcase
    end

    // Sequencer state, working registers and the response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The response register fills from the last step and empties when taken.
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_init <= 1'b0;
                        r_ord  <= i_req.order;
                        r_idx  <= i_req.page_index;
                        r_blk  <= '0;
                        unique case (i_req.mode)
                            bpa_pkg::MODE_INIT:  r_state <= S_INIT0;
                            bpa_pkg::MODE_ALLOC: r_state <= S_ALLOC0;
                            bpa_pkg::MODE_FREE:  r_state <= S_FREE0;
                            default: begin
                                r_st    <= bpa_pkg::ST_BAD;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INIT0: begin
                    r_init  <= 1'b1;
                    r_i     <= '0;
                    r_state <= S_MARK;
                end
                S_MARK: begin
                    if (r_i < i_stat.pool_pages) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_IFREE;
                    end
                end
                S_IFREE: begin
                    if (r_i < i_stat.pool_pages) begin
                        r_p     <= r_i[bpa_pkg::PAGE_W-1:0];
                        r_state <= S_FB1;
                    end else begin
                        r_st    <= bpa_pkg::ST_OK;
                        r_state <= S_DONE;
                    end
                end
                S_FREE0: begin
                    r_p <= r_idx;
                    if (bpa_pkg::LINK_W'(r_idx) >= i_stat.pool_pages) begin
                        r_st    <= bpa_pkg::ST_BAD;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_FREE1;
                    end
                end
                S_FREE1: begin
                    if (!i_stat.meta_rdata.alloc) begin
                        r_st    <= bpa_pkg::ST_BAD;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_FB1;
                    end
                end
                // Free the block at r_p and push it on its list.
                S_FB1: begin
                    r_o     <= clip_ord;
                    r_arg   <= r_p;
                    r_ret   <= S_MG0;
                    r_state <= S_PUSH1;
                end
                S_MG0: begin
                    if (r_o < bpa_pkg::TOP_ORD) begin
                        r_ret   <= S_MG1;
                        r_state <= S_BD0;
                    end else begin
                        r_state <= S_FBEND;
                    end
                end
                S_MG1: begin
                    r_state <= (r_b == bpa_pkg::NIL_LINK) ? S_FBEND : S_MG2;
                end
                S_MG2: begin
                    if (i_stat.meta_rdata.alloc || (i_stat.meta_rdata.ord != r_o)) begin
                        r_state <= S_FBEND;
                    end else begin
                        r_arg   <= r_p;
                        r_ret   <= S_MG3;
                        r_state <= S_DROP0;
                    end
                end
                S_MG3: begin
                    r_arg   <= b_page;
                    r_ret   <= S_MG4;
                    r_state <= S_DROP0;
                end
                S_MG4: begin
                    r_p     <= merged_p;
                    r_o     <= r_o + 1'b1;
                    r_arg   <= merged_p;
                    r_ret   <= S_MG0;
                    r_state <= S_PUSH1;
                end
                S_FBEND: begin
                    if (r_init) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_IFREE;
                    end else begin
                        r_st    <= bpa_pkg::ST_OK;
                        r_state <= S_DONE;
                    end
                end
                S_ALLOC0: begin
                    r_o <= r_ord;
                    if (r_ord > bpa_pkg::TOP_ORD) begin
                        r_st    <= bpa_pkg::ST_NOMEM;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_ASRCH;
                    end
                end
                // Look for the lowest non-empty list, one order a cycle.
                S_ASRCH: begin
                    if (i_stat.count != '0) begin
                        if (i_stat.head == bpa_pkg::NIL_LINK) begin
                            r_st    <= bpa_pkg::ST_NOMEM;
                            r_state <= S_DONE;
                        end else begin
                            r_p     <= i_stat.head[bpa_pkg::PAGE_W-1:0];
                            r_state <= S_ASPL;
                        end
                    end else if (r_o == bpa_pkg::TOP_ORD) begin
                        r_st    <= bpa_pkg::ST_NOMEM;
                        r_state <= S_DONE;
                    end else begin
                        r_o <= r_o + 1'b1;
                    end
                end
                S_ASPL: begin
                    r_arg   <= r_p;
                    r_ret   <= (r_o > r_ord) ? S_ASPL1 : S_AFIN;
                    r_state <= S_DROP0;
                end
                S_ASPL1: begin
                    r_o     <= r_o - 1'b1;
                    r_ret   <= S_ASPL2;
                    r_state <= S_BD0;
                end
                S_ASPL2: begin
                    r_arg   <= r_p;
                    r_ret   <= S_ASPL3;
                    r_state <= S_PUSH1;
                end
                S_ASPL3: begin
                    if (r_b != bpa_pkg::NIL_LINK) begin
                        r_arg   <= b_page;
                        r_ret   <= S_ASPL;
                        r_state <= S_PUSH1;
                    end else begin
                        r_state <= S_ASPL;
                    end
                end
                S_AFIN: begin
                    r_blk   <= r_p;
                    r_st    <= bpa_pkg::ST_OK;
                    r_state <= S_DONE;
                end
                S_PUSH1: r_state <= S_PUSH2;
                S_PUSH2: r_state <= r_ret;
                S_DROP0: r_state <= S_DROP1;
                S_DROP1: r_state <= r_ret;
                S_BD0:   r_state <= S_BD1;
                S_BD1: begin
                    r_b     <= i_stat.buddy;
                    r_state <= r_ret;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_status <= r_st;
                        r_out_block  <= r_blk;
                        r_out_free   <= i_stat.total;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A new request is taken only after the previous one has left.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while busy");

    // Only a successful allocation reports a nonzero block.
    a_block_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.block_index != '0)) |-> (o_rsp.status == bpa_pkg::ST_OK))
        else $error("block index on a failed request");

    // The reported free total never exceeds MAX_PAGES.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.free_pages <= bpa_pkg::LINK_W'(bpa_pkg::MAX_PAGES)))
        else $error("free total beyond pool size");

    // List operations stay within the order range.
    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PUSH1) || (r_state == S_DROP1)) |-> (r_o <= bpa_pkg::TOP_ORD))
        else $error("list order out of range");

endmodule

// ===== hw/rtl/buddy_page_allocator_top.sv =====
// Top level of the buddy page allocator: controller, datapath and ports.
//
//  Channel   Direction  Handshake          Payload
//  i_req     in         valid/ready        mode, order, page_index
//  o_rsp     out        valid/ready        status, block_index, free_pages
//  i_cfg     in         write enable only  index, 52-bit data
//
// One request is handled at a time; a list push runs through S_PUSH1 and S_PUSH2, an
// unlink through S_DROP0 and S_DROP1 and a buddy lookup through S_BD0 and S_BD1. A free
// frees and pushes the block, then merges upward while the buddy is free at the same
// order. An allocate searches upward from its order and splits the block down, pushing
// the halves; a rejected request is answered without list work. Init marks every pool
// page allocated, then frees each page in turn. The page record and link memories have
// one write and one registered read port each. Reset clears the lists, counts and total;
// page memories are filled by init. A waiting response holds in its register; the next
// request is taken meanwhile and stalls in its last step until that register is free.
module buddy_page_allocator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bpa_req_if.sink                        i_req,
    bpa_rsp_if.source                      o_rsp
);

    bpa_pkg::t_dp_cmd  dp_cmd;
    bpa_pkg::t_dp_stat dp_stat;

    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    bpa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

// ===== verif/bpa_checker.sv =====
// Checker for the buddy page allocator: it models the page pool and compares every response.
module bpa_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bpa_req_if                             i_req,
    bpa_rsp_if                             o_rsp,
    output int                             o_fail_count,
    output int                             o_pending
);
    import bpa_pkg::*;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] block;
        logic [LINK_W-1:0] free_pages;
    } t_word;

    // Register copies and the modeled pool.
    logic [BASE_W-1:0] cfg_base;
    logic [PCNT_W-1:0] cfg_count;
    logic [63:0]       pool_base;
    int                pool_pages;
    bit                pg_alloc [MAX_PAGES];
    int                pg_ord   [MAX_PAGES];
    int                nxt      [MAX_PAGES];
    int                prv      [MAX_PAGES];
    int                head     [NUM_ORDERS];
    int                cnt      [NUM_ORDERS];
    int                total_free;
    t_word             expected_words [$];

    assign o_pending = expected_words.size();

    function automatic void push_free(int o, int p);
        int h;
        h = head[o];
        nxt[p] = h;
        prv[p] = MAX_PAGES;
        if (h < MAX_PAGES) prv[h] = p;
        head[o] = p;
        cnt[o]++;
    endfunction

    function automatic void unlink_free(int o, int p);
        int n;
        int v;
        n = nxt[p];
        v = prv[p];
        if (v < MAX_PAGES) nxt[v] = n;
        else head[o] = n;
        if (n < MAX_PAGES) prv[n] = v;
        cnt[o]--;
    endfunction

    function automatic int buddy_index(int p, int o);
        logic [63:0] b;
        logic [63:0] r;
        b = (pool_base + 64'(p)) ^ (64'd1 << o);
        if (b < pool_base) return MAX_PAGES;
        r = b - pool_base;
        if (r >= 64'(pool_pages)) return MAX_PAGES;
        return int'(r);
    endfunction

    // Release a block and merge upward while the buddy is free at the same order.
    function automatic void release_block(int p);
        int o;
        int b;
        o = pg_ord[p];
        if (o >= NUM_ORDERS) o = NUM_ORDERS - 1;
        pg_alloc[p] = 1'b0;
        pg_ord[p] = o;
        push_free(o, p);
        total_free += 1 << o;
        while (o + 1 < NUM_ORDERS) begin
            b = buddy_index(p, o);
            if (b >= MAX_PAGES || pg_alloc[b] || pg_ord[b] != o) break;
            unlink_free(o, p);
            unlink_free(o, b);
            if (b < p) p = b;
            o++;
            pg_ord[p] = o;
            push_free(o, p);
        end
    endfunction

    // Apply one request word to the pool and return the response it should give.
    function automatic t_word serve_request(logic [1:0] mode, int ord, int idx);
        t_word w;
        int o;
        int p;
        int b;
        w.status = ST_OK;
        w.block = '0;
        if (mode == MODE_INIT) begin
            pool_base = 64'(cfg_base);
            pool_pages = (cfg_count > MAX_PAGES) ? MAX_PAGES : int'(cfg_count);
            for (int k = 0; k < NUM_ORDERS; k++) begin
                head[k] = MAX_PAGES;
                cnt[k] = 0;
            end
            total_free = 0;
            for (int i = 0; i < pool_pages; i++) begin
                pg_alloc[i] = 1'b1;
                pg_ord[i] = 0;
            end
            for (int i = 0; i < pool_pages; i++) release_block(i);
        end else if (mode == MODE_ALLOC) begin
            o = ord;
            while (o < NUM_ORDERS && cnt[o] == 0) o++;
            if (ord >= NUM_ORDERS || o >= NUM_ORDERS || head[o] >= MAX_PAGES) begin
                w.status = ST_NOMEM;
            end else begin
                p = head[o];
                while (o > ord) begin
                    unlink_free(o, p);
                    o--;
                    pg_ord[p] = o;
                    b = buddy_index(p, o);
                    if (b < MAX_PAGES) begin
                        pg_ord[b] = o;
                        pg_alloc[b] = 1'b0;
                    end
                    push_free(o, p);
                    if (b < MAX_PAGES) push_free(o, b);
                end
                unlink_free(ord, p);
                pg_alloc[p] = 1'b1;
                pg_ord[p] = ord;
                total_free -= 1 << ord;
                w.block = PAGE_W'(p);
            end
        end else if (mode == MODE_FREE) begin
            if (idx >= pool_pages || !pg_alloc[idx]) w.status = ST_BAD;
            else release_block(idx);
        end else begin
            w.status = ST_BAD;
        end
        w.free_pages = LINK_W'(total_free);
        return w;
    endfunction

    // Follow configuration writes, accepted requests and accepted responses.
    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (!i_rst_n) begin
            cfg_base <= '0;
            cfg_count <= PCNT_W'(MAX_PAGES);
            pool_base = '0;
            pool_pages = 0;
            total_free = 0;
            for (int k = 0; k < NUM_ORDERS; k++) begin
                head[k] = MAX_PAGES;
                cnt[k] = 0;
            end
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BASE_FRAME) cfg_base <= i_cfg_data;
                else cfg_count <= i_cfg_data[PCNT_W-1:0];
            end
            if (i_req.valid && i_req.ready)
                expected_words.push_back(serve_request(i_req.mode, int'(i_req.order),
                                                       int'(i_req.page_index)));
            if (o_rsp.valid && o_rsp.ready) begin
                got.status = o_rsp.status;
                got.block = o_rsp.block_index;
                got.free_pages = o_rsp.free_pages;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected response status=%0d block=%0d free=%0d",
                             $time, got.status, got.block, got.free_pages);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected status=%0d block=%0d free=%0d",
                                 $time, want.status, want.block, want.free_pages);
                        $display("%0t:          actual   status=%0d block=%0d free=%0d",
                                 $time, got.status, got.block, got.free_pages);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== verif/tb_buddy_page_allocator_top.sv =====
// Testbench top for the buddy page allocator: stimulus, flow control and verdict.
module tb_buddy_page_allocator_top;
    import bpa_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    // Mode value that no request type uses.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycles;
    int                    sent;
    int                    answered;
    int                    burst_left;
    bit                    hold_off;
    logic [1:0]            sent_modes [$];
    int                    live_blocks [$];

    bpa_req_if req ();
    bpa_rsp_if rsp ();

    buddy_page_allocator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req),
        .o_rsp       (rsp)
    );

    bpa_checker pool_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_req        (req),
        .o_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Cycle limit guards against a hang.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_buddy_page_allocator_top: FAIL");
            $finish;
        end
    end

    // Track outstanding words and the blocks that are currently handed out.
    always @(posedge i_clk) begin
        logic [1:0] m;
        if (i_rst_n && req.valid && req.ready) begin
            sent <= sent + 1;
            sent_modes.push_back(req.mode);
        end
        if (i_rst_n && rsp.valid && rsp.ready) begin
            answered <= answered + 1;
            m = sent_modes.pop_front();
            if (m == MODE_INIT) live_blocks.delete();
            else if (m == MODE_ALLOC && rsp.status == ST_OK)
                live_blocks.push_back(int'(rsp.block_index));
        end
    end

    // Receiver: alternating windows of full rate and random stalls, plus a long hold-off.
    initial begin
        int window;
        rsp.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                rsp.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end else begin
                window = $urandom_range(0, 2);
                repeat ($urandom_range(20, 120)) begin
                    if (window == 0) rsp.ready <= 1'b1;
                    else if (window == 1) rsp.ready <= ($urandom_range(0, 3) != 0);
                    else rsp.ready <= ($urandom_range(0, 3) == 0);
                    @(posedge i_clk);
                end
            end
        end
    end

    // Offer one request word, with bursts separated by random gaps.
    task automatic send_word(logic [1:0] mode, logic [ORD_W-1:0] ord,
                             logic [PAGE_W-1:0] idx);
        if (burst_left == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        req.valid <= 1'b1;
        req.mode <= mode;
        req.order <= ord;
        req.page_index <= idx;
        do @(posedge i_clk); while (!req.ready);
    endtask

    // Let every response drain before touching the registers.
    task automatic wait_idle();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (answered != sent) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed alloc/free traffic, with some stray frees, oversized orders, re-inits and unused modes.
    task automatic random_words(int n, int pool_size);
        int pick;
        int k;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_word(MODE_ALLOC, ($urandom_range(0, 9) == 0) ?
                          ORD_W'($urandom_range(0, 15)) : ORD_W'($urandom_range(0, 3)),
                          PAGE_W'($urandom));
            end else if (pick < 85 && live_blocks.size() != 0) begin
                k = $urandom_range(0, live_blocks.size() - 1);
                send_word(MODE_FREE, ORD_W'($urandom), PAGE_W'(live_blocks[k]));
                live_blocks.delete(k);
            end else if (pick < 96) begin
                send_word(MODE_FREE, ORD_W'($urandom), PAGE_W'($urandom));
            end else if (pick < 98 && pool_size <= 256) begin
                send_word(MODE_INIT, ORD_W'($urandom), PAGE_W'($urandom));
            end else begin
                send_word(MODE_UNUSED, ORD_W'($urandom), PAGE_W'($urandom));
            end
        end
    endtask

    task automatic run_phase(logic [BASE_W-1:0] base, logic [PCNT_W-1:0] count, int n);
        int pool_size;
        pool_size = (count > MAX_PAGES) ? MAX_PAGES : int'(count);
        wait_idle();
        write_reg(CFG_BASE_FRAME, base);
        write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(count));
        send_word(MODE_INIT, '0, '0);
        random_words(n, pool_size);
    endtask

    initial begin
        cycles = 0;
        sent = 0;
        answered = 0;
        burst_left = 0;
        hold_off = 1'b0;
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        req.valid <= 1'b0;
        req.mode <= MODE_INIT;
        req.order <= '0;
        req.page_index <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: requests before any init find an empty pool.
        send_word(MODE_ALLOC, '0, '0);
        send_word(MODE_FREE, '0, '0);
        send_word(MODE_UNUSED, '1, '1);

        // Full default pool, then extremes of order and index.
        send_word(MODE_INIT, '1, '1);
        send_word(MODE_ALLOC, ORD_W'(NUM_ORDERS - 1), '0);
        send_word(MODE_ALLOC, ORD_W'(NUM_ORDERS - 1), '0);
        send_word(MODE_ALLOC, ORD_W'(NUM_ORDERS), '0);
        send_word(MODE_ALLOC, '1, '0);
        send_word(MODE_ALLOC, '0, '0);
        send_word(MODE_FREE, '0, '1);
        send_word(MODE_FREE, '0, PAGE_W'(1));
        send_word(MODE_FREE, '0, '0);
        send_word(MODE_FREE, '0, '0);
        send_word(MODE_FREE, '0, 12'd2048);
        send_word(MODE_FREE, '0, 12'd1024);

        // Pressure: stall the response side while requests keep coming.
        hold_off = 1'b1;
        random_words(40, MAX_PAGES);
        random_words(120, MAX_PAGES);

        run_phase(BASE_W'({$urandom, $urandom}), PCNT_W'($urandom_range(2, 100)), 150);
        run_phase('1, PCNT_W'(1), 30);
        run_phase(BASE_W'(5), PCNT_W'(37), 150);
        run_phase('0, '0, 20);
        run_phase(BASE_W'({$urandom, $urandom}), '1, 100);
        run_phase(BASE_W'(3), PCNT_W'(200), 200);
        run_phase('0, PCNT_W'(MAX_PAGES + 1), 60);

        // Drain and settle.
        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_buddy_page_allocator_top: PASS");
        end else begin
            $display("tb_buddy_page_allocator_top: FAIL");
        end
        $finish;
    end
endmodule
